// File: rtl/pitc_pkg.sv
// Shared types and constants for the point-in-triangle classifier.
package pitc_pkg;

	// Configuration register index width and register indexes.
	localparam int unsigned CFG_INDEX_WIDTH = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX0_X = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX0_Y = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX1_X = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX1_Y = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX2_X = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX2_Y = 3'd5;

	// Number of triangle vertices and edges.
	localparam int unsigned NUM_VERTICES = 3;

	// Classification codes.
	typedef enum logic [1:0] {
		LOC_OUTSIDE = 2'd0,
		LOC_INSIDE  = 2'd1,
		LOC_BORDER  = 2'd2,
		LOC_INVALID = 2'd3
	} loc_t;

	// Per-edge findings handed from an edge unit to the top level.
	typedef struct packed {
		logic on_edge;
		logic crossed;
	} edge_flags_t;

endpackage

// File: rtl/pitc_edge.sv
// One triangle edge: cross-product sign, bounding box test and ray crossing test.
module pitc_edge #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	output pitc_pkg::edge_flags_t         flags
);

	localparam int unsigned DW = COORD_WIDTH + 1;
	localparam int unsigned PW = 2 * DW;

	logic signed [DW-1:0] dbx_s1;
	logic signed [DW-1:0] dby_s1;
	logic signed [DW-1:0] dpx_s1;
	logic signed [DW-1:0] dpy_s1;
	logic                 a_up_s1;
	logic                 b_up_s1;
	logic                 in_box_s1;

	logic signed [PW-1:0] lhs_s2;
	logic signed [PW-1:0] rhs_s2;
	logic                 a_up_s2;
	logic                 b_up_s2;
	logic                 in_box_s2;

	logic                 in_x;
	logic                 in_y;
	logic                 gt;
	logic                 lt;

	// The point lies within the edge's bounding box, bounds included.
	assign in_x = ((px >= ax) && (px <= bx)) || ((px >= bx) && (px <= ax));
	assign in_y = ((py >= ay) && (py <= by)) || ((py >= by) && (py <= ay));

	// Stage 1: exact differences, the height comparisons and the bounding box result.
	always_ff @(posedge clk) begin
		dbx_s1    <= DW'(bx) - DW'(ax);
		dby_s1    <= DW'(by) - DW'(ay);
		dpx_s1    <= DW'(px) - DW'(ax);
		dpy_s1    <= DW'(py) - DW'(ay);
		a_up_s1   <= ay > py;
		b_up_s1   <= by > py;
		in_box_s1 <= in_x && in_y;
	end

	// Stage 2: the two products of the cross-product determinant.
	always_ff @(posedge clk) begin
		lhs_s2    <= dbx_s1 * dpy_s1;
		rhs_s2    <= dpx_s1 * dby_s1;
		a_up_s2   <= a_up_s1;
		b_up_s2   <= b_up_s1;
		in_box_s2 <= in_box_s1;
	end

	// Determinant sign, border test and half-open crossing rule.
	// Swapping the endpoints negates the sign, so the lower endpoint
	// never has to be selected explicitly.
	assign gt = lhs_s2 > rhs_s2;
	assign lt = lhs_s2 < rhs_s2;

	always_comb begin
		flags.on_edge = !gt && !lt && in_box_s2;
		flags.crossed = (a_up_s2 != b_up_s2) && (a_up_s2 ? gt : lt);
	end

endmodule

// File: rtl/point_in_triangle_classifier_top.sv
// Throughput: one query per cycle; busy stays low, the pipeline never stalls.
// Three stages: vertex differences, determinant products, sign compare and classify.
// The receiver cannot stall; done marks each result for exactly one cycle.
// Reset (arst_n low) clears all vertices to zero and drops every in-flight item.
module point_in_triangle_classifier_top #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [COORD_WIDTH-1:0]           query_x,
	input  logic signed [COORD_WIDTH-1:0]           query_y,
	input  logic                                    cfg_we,
	input  logic [pitc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [COORD_WIDTH-1:0]                  cfg_data,
	output logic                                    done,
	output logic [1:0]                              location
);

	localparam int unsigned NV = pitc_pkg::NUM_VERTICES;

	logic signed [COORD_WIDTH-1:0] vx_q [NV];
	logic signed [COORD_WIDTH-1:0] vy_q [NV];

	logic                  accept;
	logic                  all_equal;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	logic                  invalid_s1;
	logic                  invalid_s2;
	pitc_pkg::loc_t        loc_s3;
	pitc_pkg::loc_t        loc_next;
	pitc_pkg::edge_flags_t flags [NV];

	// Every cycle takes a new item.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Vertex registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) begin
				vx_q[i] <= '0;
				vy_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				pitc_pkg::REG_VERTEX0_X: vx_q[0] <= cfg_data;
				pitc_pkg::REG_VERTEX0_Y: vy_q[0] <= cfg_data;
				pitc_pkg::REG_VERTEX1_X: vx_q[1] <= cfg_data;
				pitc_pkg::REG_VERTEX1_Y: vy_q[1] <= cfg_data;
				pitc_pkg::REG_VERTEX2_X: vx_q[2] <= cfg_data;
				pitc_pkg::REG_VERTEX2_Y: vy_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A triangle whose vertices all coincide is invalid.
	assign all_equal = (vx_q[0] == vx_q[1]) && (vy_q[0] == vy_q[1]) &&
	                   (vx_q[1] == vx_q[2]) && (vy_q[1] == vy_q[2]);

	// Valid bits travel alongside the edge units' data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// The invalid flag follows the item through the pipeline.
	always_ff @(posedge clk) begin
		invalid_s1 <= all_equal;
		invalid_s2 <= invalid_s1;
	end

	// One edge unit per triangle edge: v0->v1, v1->v2, v2->v0.
	for (genvar e = 0; e < NV; e++) begin : g_edge
		pitc_edge #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_edge (
			.clk   (clk),
			.ax    (vx_q[e]),
			.ay    (vy_q[e]),
			.bx    (vx_q[(e + 1) % NV]),
			.by    (vy_q[(e + 1) % NV]),
			.px    (query_x),
			.py    (query_y),
			.flags (flags[e])
		);
	end

	// Combine the edge findings; an invalid triangle wins over all, and border wins over the crossing parity.
	always_comb begin
		priority if (invalid_s2) begin
			loc_next = pitc_pkg::LOC_INVALID;
		end else if (flags[0].on_edge || flags[1].on_edge || flags[2].on_edge) begin
			loc_next = pitc_pkg::LOC_BORDER;
		end else if (flags[0].crossed ^ flags[1].crossed ^ flags[2].crossed) begin
			loc_next = pitc_pkg::LOC_INSIDE;
		end else begin
			loc_next = pitc_pkg::LOC_OUTSIDE;
		end
	end

	// Stage 3: result register.
	always_ff @(posedge clk) begin
		loc_s3 <= loc_next;
	end

	assign done     = valid_s3;
	assign location = loc_s3;

endmodule

// File: rtl/pitc_checker.sv
// Port-level checker for the point-in-triangle classifier and its bind.
module pitc_checker #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic [COORD_WIDTH-1:0] query_x,
	input logic [COORD_WIDTH-1:0] query_y,
	input logic                   cfg_we,
	input logic                   done,
	input logic [1:0]             location
);

	// Every accepted item yields a result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted item produced no result");

	// No result appears without a matching accepted item.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching item");

	// The same query against unchanged vertices classifies the same way.
	a_repeat_same: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && $past(start && !busy) && !$past(cfg_we) &&
		 (query_x == $past(query_x)) && (query_y == $past(query_y)))
		|-> ##3 (location == $past(location)))
		else $error("repeated query gave a different class");

	// Invalidity depends on the vertices alone, not on the query.
	a_invalid_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && !$past(cfg_we, 4))
		|-> ((location == pitc_pkg::LOC_INVALID) ==
		     ($past(location) == pitc_pkg::LOC_INVALID)))
		else $error("invalid class changed without a vertex write");

endmodule

bind point_in_triangle_classifier_top pitc_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_pitc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.query_x  (query_x),
	.query_y  (query_y),
	.cfg_we   (cfg_we),
	.done     (done),
	.location (location)
);

// File: sim/point_in_triangle_classifier_top_tb.sv
// Self-checking testbench for the point-in-triangle classifier: directed and random queries.
module point_in_triangle_classifier_top_tb;

	localparam int unsigned COORD_WIDTH = 16;
	localparam int COORD_MIN = -32768;
	localparam int COORD_MAX = 32767;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 50;

	// Register indexes past the vertex set; writes there must change nothing.
	localparam logic [pitc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [pitc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

	// Keeps its own copy of the vertices and the locations still owed by the block.
	class location_scoreboard;
		logic signed [COORD_WIDTH-1:0] vx[3];
		logic signed [COORD_WIDTH-1:0] vy[3];
		pitc_pkg::loc_t owed_q[$];
		int errors;
		int checked;
		int seen[4];

		function new();
			for (int i = 0; i < 3; i++) begin
				vx[i] = '0;
				vy[i] = '0;
			end
			errors = 0;
			checked = 0;
			for (int i = 0; i < 4; i++)
				seen[i] = 0;
		endfunction

		function void note_config(logic [pitc_pkg::CFG_INDEX_WIDTH-1:0] idx,
				logic [COORD_WIDTH-1:0] data);
			case (idx)
				pitc_pkg::REG_VERTEX0_X: vx[0] = data;
				pitc_pkg::REG_VERTEX0_Y: vy[0] = data;
				pitc_pkg::REG_VERTEX1_X: vx[1] = data;
				pitc_pkg::REG_VERTEX1_Y: vy[1] = data;
				pitc_pkg::REG_VERTEX2_X: vx[2] = data;
				pitc_pkg::REG_VERTEX2_Y: vy[2] = data;
				default: ;
			endcase
		endfunction

		// Sign of the cross product (b - a) x (c - a).
		function int turn_sign(longint ax, longint ay, longint bx, longint by,
				longint cx, longint cy);
			longint l;
			longint r;
			l = (bx - ax) * (cy - ay);
			r = (cx - ax) * (by - ay);
			if (l > r)
				return 1;
			if (l < r)
				return -1;
			return 0;
		endfunction

		function pitc_pkg::loc_t classify(logic signed [COORD_WIDTH-1:0] qx,
				logic signed [COORD_WIDTH-1:0] qy);
			longint px;
			longint py;
			longint ax, ay, bx, by;
			longint lx, ly, hx, hy;
			int crossings;
			bit border;
			bit a_up;
			bit b_up;
			px = longint'(qx);
			py = longint'(qy);
			crossings = 0;
			border = 0;
			if (vx[0] == vx[1] && vy[0] == vy[1] && vx[1] == vx[2] && vy[1] == vy[2])
				return pitc_pkg::LOC_INVALID;
			for (int i = 0; i < 3; i++) begin
				ax = longint'(vx[i]);
				ay = longint'(vy[i]);
				bx = longint'(vx[(i + 1) % 3]);
				by = longint'(vy[(i + 1) % 3]);
				// Collinear and inside the edge's bounding box, bounds included.
				if (turn_sign(ax, ay, bx, by, px, py) == 0 &&
						px >= (ax < bx ? ax : bx) && px <= (ax < bx ? bx : ax) &&
						py >= (ay < by ? ay : by) && py <= (ay < by ? by : ay))
					border = 1;
				// Half-open crossing of the leftward ray; horizontal edges never count.
				a_up = ay > py;
				b_up = by > py;
				if (a_up != b_up) begin
					if (a_up) begin
						lx = bx; ly = by; hx = ax; hy = ay;
					end else begin
						lx = ax; ly = ay; hx = bx; hy = by;
					end
					if (turn_sign(lx, ly, hx, hy, px, py) < 0)
						crossings++;
				end
			end
			if (border)
				return pitc_pkg::LOC_BORDER;
			if (crossings % 2 == 1)
				return pitc_pkg::LOC_INSIDE;
			return pitc_pkg::LOC_OUTSIDE;
		endfunction

		function void note_query(logic signed [COORD_WIDTH-1:0] qx,
				logic signed [COORD_WIDTH-1:0] qy);
			owed_q.push_back(classify(qx, qy));
		endfunction

		function void check_location(logic [1:0] got);
			pitc_pkg::loc_t want;
			if (owed_q.size() == 0) begin
				$error("location: unexpected result %0d with no query outstanding", got);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			checked++;
			seen[want]++;
			if (got !== want) begin
				$error("location mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_WIDTH-1:0] query_x;
	logic signed [COORD_WIDTH-1:0] query_y;
	logic cfg_we;
	logic [pitc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [COORD_WIDTH-1:0] cfg_data;
	logic done;
	logic [1:0] location;

	location_scoreboard sb;
	int cycles = 0;
	int burst_left;
	int max_gap;
	int settings_loaded;
	int tri_x[3];
	int tri_y[3];

	point_in_triangle_classifier_top #(
		.COORD_WIDTH(COORD_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.query_x(query_x),
		.query_y(query_y),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.location(location)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Monitor: results are checked, accepted items and register writes recorded.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_location(location);
			if (start && !busy)
				sb.note_query(query_x, query_y);
			if (cfg_we)
				sb.note_config(cfg_index, cfg_data);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int clamp_coord(int v);
		if (v < COORD_MIN)
			return COORD_MIN;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	task automatic write_reg(input logic [pitc_pkg::CFG_INDEX_WIDTH-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[COORD_WIDTH-1:0];
		@(posedge clk);
	endtask

	// Loads all six vertex registers, sometimes with a stray write to a spare index.
	task automatic load_triangle(input int x0, input int y0, input int x1, input int y1,
			input int x2, input int y2);
		tri_x[0] = x0; tri_y[0] = y0;
		tri_x[1] = x1; tri_y[1] = y1;
		tri_x[2] = x2; tri_y[2] = y2;
		if ($urandom_range(2) == 0)
			write_reg(REG_SPARE_6, int'($urandom_range(16'hffff)));
		write_reg(pitc_pkg::REG_VERTEX0_X, x0);
		write_reg(pitc_pkg::REG_VERTEX0_Y, y0);
		write_reg(pitc_pkg::REG_VERTEX1_X, x1);
		write_reg(pitc_pkg::REG_VERTEX1_Y, y1);
		write_reg(pitc_pkg::REG_VERTEX2_X, x2);
		write_reg(pitc_pkg::REG_VERTEX2_Y, y2);
		if ($urandom_range(2) == 0)
			write_reg(REG_SPARE_7, int'($urandom_range(16'hffff)));
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// Sends one item, opening a new burst after a random gap when the last one ran out.
	task automatic send_item(input int qx, input int qy);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(max_gap);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b1;
		query_x <= qx[COORD_WIDTH-1:0];
		query_y <= qy[COORD_WIDTH-1:0];
		do @(posedge clk); while (busy);
		burst_left--;
	endtask

	// Stops sending and waits until every owed location has come back.
	// The last item is recorded by the monitor at the edge that took it,
	// so the count is first read only after another clock edge has passed.
	task automatic settle();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Picks a random triangle: mostly small ones, plus full-range and degenerate shapes.
	task automatic random_triangle();
		int kind;
		int span;
		int cx, cy, dx, dy;
		int v[6];
		kind = $urandom_range(9);
		span = ($urandom_range(3) == 0) ? 2000 : rand_between(2, 60);
		cx = rand_between(COORD_MIN, COORD_MAX);
		cy = rand_between(COORD_MIN, COORD_MAX);
		for (int i = 0; i < 6; i++)
			v[i] = clamp_coord((i % 2 == 0 ? cx : cy) + rand_between(-span, span));
		case (kind)
			5: begin
				for (int i = 0; i < 6; i++)
					v[i] = rand_between(COORD_MIN, COORD_MAX);
			end
			6: begin
				for (int i = 0; i < 6; i++)
					v[i] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
			end
			7: begin
				// Two vertices coincide.
				v[2] = v[0];
				v[3] = v[1];
			end
			8: begin
				// Three vertices on one line.
				dx = rand_between(-span, span) / 2;
				dy = rand_between(-span, span) / 2;
				v[2] = clamp_coord(v[0] + dx);
				v[3] = clamp_coord(v[1] + dy);
				v[4] = clamp_coord(v[0] - dx * rand_between(1, 3));
				v[5] = clamp_coord(v[1] - dy * rand_between(1, 3));
			end
			9: begin
				v[2] = v[0]; v[3] = v[1];
				v[4] = v[0]; v[5] = v[1];
			end
			default: ;
		endcase
		load_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
	endtask

	// Picks a query aimed at the interesting spots of the current triangle.
	task automatic random_query(output int qx, output int qy);
		int lo_x, hi_x, lo_y, hi_y;
		int i, j, dx, dy, g, h, t, k;
		lo_x = tri_x[0]; hi_x = tri_x[0];
		lo_y = tri_y[0]; hi_y = tri_y[0];
		for (i = 1; i < 3; i++) begin
			if (tri_x[i] < lo_x) lo_x = tri_x[i];
			if (tri_x[i] > hi_x) hi_x = tri_x[i];
			if (tri_y[i] < lo_y) lo_y = tri_y[i];
			if (tri_y[i] > hi_y) hi_y = tri_y[i];
		end
		i = $urandom_range(2);
		j = (i + 1) % 3;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				qx = clamp_coord(rand_between(lo_x - 2, hi_x + 2));
				qy = clamp_coord(rand_between(lo_y - 2, hi_y + 2));
			end
			4: begin
				qx = tri_x[i];
				qy = tri_y[i];
			end
			5: begin
				// A lattice point on edge i, endpoints included.
				dx = tri_x[j] - tri_x[i];
				dy = tri_y[j] - tri_y[i];
				g = dx < 0 ? -dx : dx;
				h = dy < 0 ? -dy : dy;
				while (h != 0) begin
					t = g % h;
					g = h;
					h = t;
				end
				if (g == 0) begin
					qx = tri_x[i];
					qy = tri_y[i];
				end else begin
					k = $urandom_range(g);
					qx = tri_x[i] + (dx / g) * k;
					qy = tri_y[i] + (dy / g) * k;
				end
			end
			6: begin
				// Ray level with a vertex.
				qx = clamp_coord(rand_between(lo_x - 4, hi_x + 4));
				qy = tri_y[i];
			end
			7: begin
				qx = rand_between(COORD_MIN, COORD_MAX);
				qy = rand_between(COORD_MIN, COORD_MAX);
			end
			8: begin
				case ($urandom_range(3))
					0: qx = COORD_MIN;
					1: qx = COORD_MAX;
					2: qx = -1;
					default: qx = 0;
				endcase
				case ($urandom_range(3))
					0: qy = COORD_MIN;
					1: qy = COORD_MAX;
					2: qy = -1;
					default: qy = 0;
				endcase
			end
			default: begin
				qx = clamp_coord(tri_x[i] + rand_between(-1, 1));
				qy = clamp_coord(tri_y[i] + rand_between(-1, 1));
			end
		endcase
	endtask

	// Main sequence: reset, directed cases, then random phases.
	initial begin
		int qx;
		int qy;
		sb = new();
		burst_left = 0;
		max_gap = 0;
		settings_loaded = 0;
		for (int i = 0; i < 3; i++) begin
			tri_x[i] = 0;
			tri_y[i] = 0;
		end
		arst_n <= 1'b0;
		start <= 1'b0;
		query_x <= '0;
		query_y <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset vertices are all zero, so the triangle is invalid.
		send_item(0, 0);
		send_item(COORD_MIN, COORD_MAX);
		send_item(COORD_MAX, COORD_MIN);
		settle();

		// Plain triangle: inside, edges, vertices and rays level with the apex.
		load_triangle(-100, -100, 100, -100, 0, 100);
		send_item(0, 0);
		send_item(0, -100);
		send_item(100, -100);
		send_item(-300, 100);
		send_item(300, 100);
		send_item(0, 99);
		send_item(50, 0);
		send_item(1, -101);
		settle();
		write_reg(REG_SPARE_6, 16'h1234);
		write_reg(REG_SPARE_7, 16'hfedc);
		cfg_we <= 1'b0;
		send_item(0, 0);
		settle();

		// Triangle spanning the full coordinate range.
		load_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
		send_item(COORD_MAX, COORD_MAX);
		send_item(COORD_MIN, COORD_MIN);
		send_item(-1, 0);
		send_item(-100, -100);
		send_item(0, 0);
		settle();

		// Two equal vertices: a segment with a zero-length edge.
		load_triangle(0, 0, 0, 0, 10, 10);
		send_item(5, 5);
		send_item(11, 11);
		send_item(0, 0);
		settle();

		// Three collinear vertices.
		load_triangle(-5, -5, 5, 5, 0, 0);
		send_item(3, 3);
		send_item(3, 4);
		send_item(6, 6);
		settle();

		// All vertices equal away from the origin.
		load_triangle(7, -3, 7, -3, 7, -3);
		send_item(7, -3);
		send_item(0, 0);
		settle();

		// Random phases, each with its own triangle and idle pattern.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				load_triangle(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
			else
				random_triangle();
			case (phase % 3)
				0: max_gap = 0;
				1: max_gap = 3;
				default: max_gap = 30;
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				random_query(qx, qy);
				send_item(qx, qy);
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d queries over %0d triangle settings.", sb.checked,
			settings_loaded);
		$display("Expected outside %0d, inside %0d, border %0d, invalid %0d.",
			sb.seen[pitc_pkg::LOC_OUTSIDE], sb.seen[pitc_pkg::LOC_INSIDE],
			sb.seen[pitc_pkg::LOC_BORDER], sb.seen[pitc_pkg::LOC_INVALID]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
